@@ hdl/mnfa_pkg.sv @@
// Shared types and constants for the multi-node frame assembler.
`timescale 1ns / 1ps

package mnfa_pkg;

   localparam int unsigned MAX_FRAME_ELEMS = 1048576;
   localparam int unsigned NUM_NODES       = 4;
   localparam int unsigned NODE_W          = 2;
   localparam int unsigned FILL_W          = 21;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned CSR_DATA_W      = 21;

   localparam logic [FILL_W-1:0] MAX_FRAME_LIM = FILL_W'(MAX_FRAME_ELEMS);

   // Input opcodes.
   localparam logic OP_START  = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   // Packet kinds; all other codes are unknown.
   localparam logic [2:0] KIND_IMAGE = 3'd0;
   localparam logic [2:0] KIND_HK    = 3'd1;
   localparam logic [2:0] KIND_EVENT = 3'd2;
   localparam logic [2:0] KIND_MASK  = 3'd3;

   // Result status codes.
   localparam logic [1:0] ST_INCOMPLETE = 2'd0;
   localparam logic [1:0] ST_COMPLETE   = 2'd1;
   localparam logic [1:0] ST_ERROR      = 2'd2;

   // Payload store actions.
   localparam logic [1:0] STORE_DISCARD = 2'd0;
   localparam logic [1:0] STORE_IMAGE   = 2'd1;
   localparam logic [1:0] STORE_HK      = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_NODE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_ELEMS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HK_MAX      = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [2:0]  packet_kind;
      logic [1:0]  sensor_side;
      logic [1:0]  ccd_select;
      logic        last_packet;
      logic [15:0] payload_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  store_kind;
      logic [1:0]  dest_node;
      logic [19:0] dest_offset;
      logic [14:0] dest_count;
   } rsp_type;

endpackage

@@ hdl/multi_node_frame_assembler.sv @@
// Multi-node frame assembler: header tracking, node fill counters and result staging.
`timescale 1ns / 1ps

// Takes one packet header or frame start per clock unless results stall, and
// returns one result per transaction through the compute and result registers.
// The four per-node fill counters live in a small synchronous memory: the read
// is issued when a transaction is accepted, and the update is written back as
// the transaction leaves the compute stage. The most recent write is forwarded
// so that consecutive packets for the same node see the current count. A frame
// start clears the counters at once through per-entry valid bits. The result
// register is separate from the compute stage, so a new transaction is taken
// while a finished result still waits on rsp_ready. Configuration writes are
// taken in any cycle and should only be issued while the block is idle.

module multi_node_frame_assembler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mnfa_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mnfa_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mnfa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mnfa_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mnfa_pkg::*;

   // Configuration registers.
   logic [NUM_NODES-1:0] node_enable_ff;
   logic [FILL_W-1:0]    frame_elems_ff;
   logic [15:0]          hk_max_ff;

   // Frame state.
   logic [NUM_NODES-1:0] pending_ff, pending_in;
   logic [FILL_W-1:0]    fill_mem_ff [NUM_NODES];
   logic [NUM_NODES-1:0] fill_vld_ff;
   logic [FILL_W-1:0]    rd_data_ff;

   // Forwarding of the last counter write.
   logic                 wr_valid_ff;
   logic [NODE_W-1:0]    wr_node_ff;
   logic [FILL_W-1:0]    wr_data_ff;

   // Compute stage and result register.
   logic                 s1_valid_ff;
   req_type              s1_req_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;

   logic                 req_fire, s1_fire;
   logic [NODE_W-1:0]    req_node, s1_node;
   logic                 s1_has_node;
   logic [14:0]          s1_elems;
   logic [FILL_W-1:0]    limit, fill_cur, fill_new;
   logic [FILL_W:0]      fill_sum;
   logic                 fits, fill_we, err;

   assign csr_ready = 1'b1;
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_node    = {req_data.ccd_select[0], req_data.sensor_side[0]};
   assign s1_node     = {s1_req_ff.ccd_select[0], s1_req_ff.sensor_side[0]};
   assign s1_has_node = !s1_req_ff.sensor_side[1] && !s1_req_ff.ccd_select[1];
   assign s1_elems    = s1_req_ff.payload_bytes[15:1];

   assign limit = (frame_elems_ff < MAX_FRAME_LIM) ? frame_elems_ff : MAX_FRAME_LIM;

   // The memory read missed a write made at the same edge, so the last write wins.
   always_comb begin
      if (wr_valid_ff && (wr_node_ff == s1_node)) begin
         fill_cur = wr_data_ff;
      end else if (fill_vld_ff[s1_node]) begin
         fill_cur = rd_data_ff;
      end else begin
         fill_cur = '0;
      end
   end

   assign fill_sum = {1'b0, fill_cur} + (FILL_W+1)'(s1_elems);
   assign fits     = fill_sum <= {1'b0, limit};
   assign fill_new = fill_sum[FILL_W-1:0];

   always_comb begin
      rsp_in     = '0;
      pending_in = pending_ff;
      fill_we    = 1'b0;
      err        = 1'b0;
      if (s1_req_ff.opcode == OP_START) begin
         pending_in    = node_enable_ff;
         rsp_in.status = (node_enable_ff == '0) ? ST_COMPLETE : ST_INCOMPLETE;
      end else begin
         case (s1_req_ff.packet_kind)
            KIND_IMAGE: begin
               if (s1_has_node) begin
                  if (!node_enable_ff[s1_node] || !fits) begin
                     err = 1'b1;
                  end else begin
                     fill_we            = 1'b1;
                     rsp_in.store_kind  = STORE_IMAGE;
                     rsp_in.dest_node   = s1_node;
                     rsp_in.dest_offset = fill_cur[19:0];
                     rsp_in.dest_count  = s1_elems;
                  end
               end
            end
            KIND_HK: begin
               if (s1_req_ff.payload_bytes <= hk_max_ff) begin
                  rsp_in.store_kind = STORE_HK;
                  rsp_in.dest_count = s1_elems;
               end else begin
                  err = 1'b1;
               end
            end
            KIND_EVENT, KIND_MASK: begin
            end
            default: begin
               err = 1'b1;
            end
         endcase
         if (err) begin
            rsp_in        = '0;
            rsp_in.status = ST_ERROR;
            fill_we       = 1'b0;
         end else begin
            if (s1_req_ff.last_packet && s1_has_node) begin
               pending_in[s1_node] = 1'b0;
            end
            rsp_in.status = (pending_in == '0) ? ST_COMPLETE : ST_INCOMPLETE;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_enable_ff <= '1;
         frame_elems_ff <= FILL_W'(MAX_FRAME_ELEMS);
         hk_max_ff      <= 16'd64;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NODE_ENABLE: node_enable_ff <= csr_data[NUM_NODES-1:0];
            REG_FRAME_ELEMS: frame_elems_ff <= csr_data[FILL_W-1:0];
            REG_HK_MAX:      hk_max_ff      <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Fill counter memory.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_data_ff <= fill_mem_ff[req_node];
      end
      if (s1_fire && fill_we) begin
         fill_mem_ff[s1_node] <= fill_new;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '1;
         fill_vld_ff  <= '0;
         wr_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            pending_ff  <= pending_in;
            wr_valid_ff <= fill_we;
            if (s1_req_ff.opcode == OP_START) begin
               fill_vld_ff <= '0;
            end else if (fill_we) begin
               fill_vld_ff[s1_node] <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_ff     <= rsp_in;
         wr_node_ff <= s1_node;
         wr_data_ff <= fill_new;
      end
   end

   // A stored image packet never reaches past the frame limit.
   a_image_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.store_kind == STORE_IMAGE)) |->
      (({2'b0, rsp_ff.dest_offset} + 22'(rsp_ff.dest_count)) <= {1'b0, limit}))
      else $error("image packet exceeds frame limit");

   // Errors carry no store action.
   a_error_discards: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == ST_ERROR)) |->
      (rsp_ff.store_kind == STORE_DISCARD))
      else $error("error result with a store action");

   // A frame start leaves every fill counter cleared.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && (s1_req_ff.opcode == OP_START)) |=>
      ((fill_vld_ff == '0) && !wr_valid_ff))
      else $error("fill counters not cleared by frame start");

   // The forwarded write always belongs to a valid counter entry.
   a_forward_valid: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> fill_vld_ff[wr_node_ff])
      else $error("forwarded write to an invalid counter entry");

   // The compute stage only takes a new transaction when its current one leaves.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |-> !req_ready)
      else $error("compute stage overwritten while stalled");

endmodule

@@ tb/frame_result_checker.sv @@
// Result predictor and checker for the multi-node frame assembler.
`timescale 1ns / 1ps

module frame_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  mnfa_pkg::req_type                req_data,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  mnfa_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [mnfa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mnfa_pkg::CSR_DATA_W-1:0]  csr_data,
   output int unsigned                      mismatch_count,
   output int unsigned                      results_owed
);
   import mnfa_pkg::*;

   logic [NUM_NODES-1:0] enabled_nodes;
   logic [FILL_W-1:0]    frame_size;
   logic [15:0]          hk_limit;
   logic [NUM_NODES-1:0] nodes_open;
   logic [FILL_W-1:0]    node_level [NUM_NODES];
   rsp_type              awaited_results [$];

   function automatic logic [1:0] frame_state();
      return (nodes_open == '0) ? ST_COMPLETE : ST_INCOMPLETE;
   endfunction

   // Applies one header to the tracked frame and returns the result it must produce.
   function automatic rsp_type assemble_header(input req_type hdr);
      rsp_type           res;
      logic [NODE_W-1:0] node;
      logic              addressed;
      logic              rejected;
      int unsigned       limit;
      int unsigned       level;
      int unsigned       elems;
      res       = '0;
      node      = {hdr.ccd_select[0], hdr.sensor_side[0]};
      addressed = (hdr.sensor_side < 2) && (hdr.ccd_select < 2);
      elems     = 32'(hdr.payload_bytes >> 1);
      rejected  = 1'b0;
      if (hdr.opcode == OP_START) begin
         nodes_open = enabled_nodes;
         foreach (node_level[n]) node_level[n] = '0;
         res.status = frame_state();
         return res;
      end
      case (hdr.packet_kind)
         KIND_IMAGE: begin
            // Side or select codes of two and up address no node and store nothing.
            if (addressed) begin
               if (!enabled_nodes[node]) begin
                  rejected = 1'b1;
               end else begin
                  limit = 32'((frame_size < MAX_FRAME_LIM) ? frame_size : MAX_FRAME_LIM);
                  level = 32'(node_level[node]);
                  if (level + elems <= limit) begin
                     res.store_kind  = STORE_IMAGE;
                     res.dest_node   = node;
                     res.dest_offset = level[19:0];
                     res.dest_count  = elems[14:0];
                     node_level[node] = FILL_W'(level + elems);
                  end else begin
                     rejected = 1'b1;
                  end
               end
            end
         end
         KIND_HK: begin
            if (hdr.payload_bytes <= hk_limit) begin
               res.store_kind = STORE_HK;
               res.dest_count = elems[14:0];
            end else begin
               rejected = 1'b1;
            end
         end
         KIND_EVENT, KIND_MASK: ;
         default: rejected = 1'b1;
      endcase
      // A rejected packet leaves the frame untouched, including its last mark.
      if (rejected) begin
         res.status = ST_ERROR;
      end else begin
         if (hdr.last_packet && addressed) nodes_open[node] = 1'b0;
         res.status = frame_state();
      end
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         enabled_nodes = 4'hF;
         frame_size    = MAX_FRAME_LIM;
         hk_limit      = 16'd64;
         nodes_open    = 4'hF;
         foreach (node_level[n]) node_level[n] = '0;
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NODE_ENABLE: enabled_nodes = csr_data[NUM_NODES-1:0];
               REG_FRAME_ELEMS: frame_size = csr_data[FILL_W-1:0];
               REG_HK_MAX:      hk_limit = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) awaited_results.push_back(assemble_header(req_data));
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction arrived with no expectation waiting: %h", rsp_data);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("store_kind", 32'(want.store_kind), 32'(rsp_data.store_kind));
               check_field("dest_node", 32'(want.dest_node), 32'(rsp_data.dest_node));
               check_field("dest_offset", 32'(want.dest_offset),
                           32'(rsp_data.dest_offset));
               check_field("dest_count", 32'(want.dest_count), 32'(rsp_data.dest_count));
            end
         end
      end
      results_owed <= awaited_results.size();
   end

endmodule

@@ tb/multi_node_frame_assembler_test.sv @@
// Stimulus, flow control and verdict for the multi-node frame assembler.
`timescale 1ns / 1ps

module multi_node_frame_assembler_test;
   import mnfa_pkg::*;

   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned LONG_HOLD      = 300;
   localparam int unsigned RANDOM_PHASES  = 8;
   localparam int unsigned PHASE_ITEMS    = 150;
   localparam int unsigned FILL_PACKETS   = 32;
   localparam logic [2:0]  KIND_FIRST_UNKNOWN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 2'd3;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_MOSTLY,
      READY_SPARSE
   } ready_style_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int unsigned     mismatch_count;
   int unsigned     results_owed;
   int unsigned     cycle_count = 0;
   int unsigned     cur_frame = MAX_FRAME_ELEMS;
   int unsigned     cur_hk = 64;
   int unsigned     burst_left = 0;
   logic            hold_request = 1'b0;
   logic            hold_taken = 1'b0;
   int unsigned     hold_left = 0;
   ready_style_type ready_style = READY_ALWAYS;
   int unsigned     style_left = 0;

   multi_node_frame_assembler DUT (.*);

   frame_result_checker checker_inst (.*);

   always #5 clock = ~clock;

   // The receiver changes its stall style every so often; a hold request starts one long stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_request != hold_taken) begin
         hold_taken <= hold_request;
         hold_left  <= LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else begin
         if (style_left == 0) begin
            ready_style <= ready_style_type'($urandom_range(0, 3));
            style_left  <= $urandom_range(10, 200);
         end else begin
            style_left <= style_left - 1;
         end
         case (ready_style)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) != 0);
            default:      rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL multi_node_frame_assembler");
      $finish;
   end

   function automatic req_type frame_start();
      req_type hdr;
      hdr               = '0;
      hdr.opcode        = OP_START;
      hdr.packet_kind   = 3'($urandom);
      hdr.sensor_side   = 2'($urandom);
      hdr.ccd_select    = 2'($urandom);
      hdr.last_packet   = 1'($urandom);
      hdr.payload_bytes = 16'($urandom);
      return hdr;
   endfunction

   function automatic req_type packet(input logic [2:0] kind, input logic [1:0] side,
                                      input logic [1:0] sel, input logic last,
                                      input int unsigned bytes);
      req_type hdr;
      hdr.opcode        = OP_PACKET;
      hdr.packet_kind   = kind;
      hdr.sensor_side   = side;
      hdr.ccd_select    = sel;
      hdr.last_packet   = last;
      hdr.payload_bytes = 16'(bytes);
      return hdr;
   endfunction

   // Mostly packets sized to the current frame, with lengths near the housekeeping limit.
   function automatic req_type random_item();
      req_type     hdr;
      int unsigned roll;
      int unsigned cap;
      int unsigned bytes;
      if ($urandom_range(0, 99) < 4) return frame_start();
      roll = $urandom_range(0, 99);
      hdr.opcode      = OP_PACKET;
      hdr.packet_kind = (roll < 62) ? KIND_IMAGE : (roll < 76) ? KIND_HK :
                        (roll < 84) ? KIND_EVENT : (roll < 92) ? KIND_MASK :
                        3'($urandom_range(KIND_FIRST_UNKNOWN, 7));
      hdr.sensor_side = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                                     : 2'($urandom_range(0, 1));
      hdr.ccd_select  = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                                     : 2'($urandom_range(0, 1));
      hdr.last_packet = ($urandom_range(0, 7) == 0);
      roll = $urandom_range(0, 99);
      if (hdr.packet_kind == KIND_HK) begin
         if (roll < 40) begin
            bytes = $urandom_range(0, cur_hk);
         end else if (roll < 70) begin
            bytes = cur_hk + $urandom_range(0, 2);
            if (bytes != 0) bytes--;
            if (bytes > 65535) bytes = 65535;
         end else begin
            bytes = $urandom_range(0, 65535);
         end
      end else begin
         cap = (cur_frame / 3 < 32767) ? cur_frame / 3 : 32767;
         if (roll < 55) begin
            bytes = 2 * $urandom_range(0, cap) + $urandom_range(0, 1);
         end else if (roll < 70) begin
            bytes = $urandom_range(0, 65535);
         end else if (roll < 80) begin
            case ($urandom_range(0, 3))
               0: bytes = 0;
               1: bytes = 1;
               2: bytes = 65534;
               default: bytes = 65535;
            endcase
         end else begin
            bytes = $urandom_range(0, 16);
         end
      end
      hdr.payload_bytes = 16'(bytes);
      return hdr;
   endfunction

   // Offers one header and waits for its transaction; bursts end in a random gap.
   task automatic send_req(input req_type hdr);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= hdr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Unused upper bits of the narrower registers carry random junk.
   task automatic configure(input logic [3:0] mask, input int unsigned frame,
                            input int unsigned hk, input bit with_spare);
      drain_results();
      write_reg(REG_NODE_ENABLE, {17'($urandom), mask});
      write_reg(REG_FRAME_ELEMS, CSR_DATA_W'(frame));
      write_reg(REG_HK_MAX, {5'($urandom), 16'(hk)});
      if (with_spare) write_reg(REG_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      cur_frame = frame;
      cur_hk    = hk;
   endtask

   initial begin
      logic [1:0] fill_node;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all nodes enabled, full frame size, small housekeeping limit.
      send_req(frame_start());
      send_req(packet(KIND_IMAGE, 0, 0, 0, 0));
      send_req(packet(KIND_IMAGE, 0, 0, 0, 65535));
      send_req(packet(KIND_IMAGE, 1, 0, 1, 100));
      send_req(packet(KIND_IMAGE, 0, 1, 0, 1));
      send_req(packet(KIND_IMAGE, 1, 1, 0, 65534));
      send_req(packet(KIND_IMAGE, 2, 0, 1, 40));
      send_req(packet(KIND_IMAGE, 0, 3, 1, 40));
      send_req(packet(KIND_HK, 3, 3, 0, 64));
      send_req(packet(KIND_HK, 0, 0, 1, 65));
      send_req(packet(KIND_HK, 1, 1, 0, 0));
      send_req(packet(KIND_EVENT, 0, 0, 1, 65535));
      send_req(packet(KIND_MASK, 0, 1, 1, 7));
      for (int k = int'(KIND_FIRST_UNKNOWN); k <= 7; k++)
         send_req(packet(3'(k), 1, 1, 1, 8));
      send_req(packet(KIND_IMAGE, 1, 1, 1, 2));
      send_req(packet(KIND_EVENT, 0, 0, 0, 0));

      // No node enabled: a start completes at once and image data is refused.
      configure(4'h0, 1, 0, 1'b0);
      send_req(frame_start());
      send_req(packet(KIND_IMAGE, 0, 0, 0, 2));
      send_req(packet(KIND_HK, 0, 0, 0, 0));
      send_req(packet(KIND_HK, 0, 0, 0, 1));

      // One-element frames on two nodes.
      configure(4'h5, 1, 65535, 1'b0);
      send_req(frame_start());
      send_req(packet(KIND_IMAGE, 0, 0, 0, 2));
      send_req(packet(KIND_IMAGE, 0, 0, 0, 2));
      send_req(packet(KIND_IMAGE, 0, 0, 0, 1));
      send_req(packet(KIND_HK, 0, 0, 0, 65535));
      send_req(packet(KIND_IMAGE, 1, 0, 0, 2));
      send_req(packet(KIND_IMAGE, 0, 1, 1, 3));

      // Fill one node exactly to the clamped frame limit, then overrun it.
      configure(4'hF, 21'h1FFFFF, $urandom_range(0, 65535), 1'b0);
      fill_node = 2'($urandom);
      send_req(frame_start());
      repeat (FILL_PACKETS)
         send_req(packet(KIND_IMAGE, 2'(fill_node[0]), 2'(fill_node[1]), 0,
                         65534 + $urandom_range(0, 1)));
      send_req(packet(KIND_IMAGE, 2'(fill_node[0]), 2'(fill_node[1]), 0, 64));
      send_req(packet(KIND_IMAGE, 2'(fill_node[0]), 2'(fill_node[1]), 0, 0));
      send_req(packet(KIND_IMAGE, 2'(fill_node[0]), 2'(fill_node[1]), 1, 2));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: configure(4'hF, $urandom_range(1, 64), 0, 1'b1);
            1: configure(4'hF, MAX_FRAME_ELEMS, 65535, 1'b0);
            2: configure(4'h0, 1, $urandom_range(0, 65535), 1'b0);
            3: configure(4'($urandom), 21'h1FFFFF, $urandom_range(0, 65535), 1'b0);
            default: configure(4'($urandom),
                               ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2097151)
                                                           : $urandom_range(1, 4096),
                               $urandom_range(0, 65535), 1'b0);
         endcase
         // The receiver stops for a long stretch while headers keep coming.
         if (p == 1) hold_request <= ~hold_request;
         send_req(frame_start());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) drain_results();
            send_req(random_item());
         end
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("PASS multi_node_frame_assembler");
      end else begin
         $display("FAIL multi_node_frame_assembler");
      end
      $finish;
   end

endmodule
